// ===== rtl/tts_pkg.sv =====
// shared types, constants and mode table for the temperature trend slope block
package tts_pkg;

  localparam int SUM_W   = 17;   // rounded group sum, covers the widest sample setting
  localparam int CNT_W   = 5;
  localparam int PER_W   = 10;
  localparam int MODE_W  = 4;
  localparam int DEN_W   = 48;
  localparam int QNUM_W  = 32;
  localparam int SLOPE_W = 16;

  localparam logic [MODE_W-1:0] MODE_RESET = 4'd8;
  localparam logic [MODE_W-1:0] MODE_LAST  = 4'd9;

  localparam int SLOPE_LIMIT   = 35790;
  localparam int MS_PER_MINUTE = 60000;

  typedef struct packed {
    logic [SUM_W-1:0] num;     // group sum plus half the count
    logic [CNT_W-1:0] cnt;     // samples in the group
    logic [CNT_W-1:0] navg;    // averaging count of the mode
    logic [PER_W-1:0] period;  // sample period of the mode, ms
  } tts_job_t;

  function automatic logic [CNT_W-1:0] mode_avg(input logic [MODE_W-1:0] mode);
    logic [CNT_W-1:0] n;
    unique case (mode)
      4'd0, 4'd1: n = 5'd4;
      4'd2:       n = 5'd9;
      4'd3:       n = 5'd14;
      default:    n = 5'd16;
    endcase
    return n;
  endfunction

  function automatic logic [PER_W-1:0] mode_period(input logic [MODE_W-1:0] mode);
    logic [PER_W-1:0] p;
    unique case (mode)
      4'd0, 4'd1: p = 10'd234;
      4'd2:       p = 10'd208;
      4'd3:       p = 10'd200;
      4'd4:       p = 10'd234;
      4'd5:       p = 10'd292;
      4'd6:       p = 10'd351;
      4'd7:       p = 10'd410;
      4'd8:       p = 10'd468;
      default:    p = 10'd527;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/tts_div.sv =====
// restoring divider, one quotient bit per cycle
module tts_div #(
  parameter int NUM_W = 32,
  parameter int DIV_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den_r;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NUM_W);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= fits ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/tts_front.sv =====
// sample accumulation and group completion
module tts_front #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         temperature_sample,
  input  logic [tts_pkg::MODE_W-1:0]     mode,
  input  logic                           q_full,
  output logic                           q_push,
  output tts_pkg::tts_job_t              q_data
);

  logic [tts_pkg::SUM_W-1:0] group_sum;
  logic [tts_pkg::CNT_W-1:0] group_count;
  logic [tts_pkg::SUM_W-1:0] sum_next;
  logic [tts_pkg::CNT_W-1:0] count_next;
  logic [tts_pkg::CNT_W-1:0] navg;
  logic                      accept;
  logic                      complete;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign navg       = tts_pkg::mode_avg(mode);
  assign sum_next   = group_sum + tts_pkg::SUM_W'(temperature_sample);
  assign count_next = group_count + 1'b1;
  assign complete   = count_next >= navg;
  assign q_push     = accept && complete;

  always_comb begin
    q_data.num    = sum_next + tts_pkg::SUM_W'(count_next >> 1);
    q_data.cnt    = count_next;
    q_data.navg   = navg;
    q_data.period = tts_pkg::mode_period(mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum   <= '0;
      group_count <= '0;
    end else if (accept) begin
      group_sum   <= complete ? '0 : sum_next;
      group_count <= complete ? '0 : count_next;
    end
  end

endmodule

// ===== rtl/tts_fifo.sv =====
// two-entry job queue between front and back
module tts_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tts_pkg::tts_job_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output tts_pkg::tts_job_t head
);

  tts_pkg::tts_job_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/tts_back.sv =====
// group averaging, history update, least-squares sweep, scaling and slope division
module tts_back #(
  parameter int HISTORY_DEPTH = 64,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  tts_pkg::tts_job_t             q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tts_pkg::SLOPE_W-1:0]   slope
);

  localparam int IDXW = $clog2(HISTORY_DEPTH);
  localparam int TOTW = SAMPLE_BITS + IDXW;
  localparam int T1W  = SAMPLE_BITS + 2 * IDXW;
  localparam int WAW  = SAMPLE_BITS + 3 * IDXW;
  localparam int DW   = tts_pkg::DEN_W;
  localparam int NW   = tts_pkg::QNUM_W;
  localparam logic [IDXW-1:0] LAST = IDXW'(HISTORY_DEPTH - 1);
  localparam logic [WAW-1:0] S1 = WAW'(HISTORY_DEPTH * (HISTORY_DEPTH - 1) / 2);
  localparam logic [DW-1:0] KW = DW'(48'(HISTORY_DEPTH) * 48'(HISTORY_DEPTH)
                                    * (48'(HISTORY_DEPTH) * 48'(HISTORY_DEPTH) - 48'd1)
                                    / 48'd12);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AVG    = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_OLD    = 4'd3;
  localparam logic [3:0] S_SWEEP  = 4'd4;
  localparam logic [3:0] S_DRAIN  = 4'd5;
  localparam logic [3:0] S_PROD   = 4'd6;
  localparam logic [3:0] S_DIFF   = 4'd7;
  localparam logic [3:0] S_HALVE  = 4'd8;
  localparam logic [3:0] S_SCALE  = 4'd9;
  localparam logic [3:0] S_QSTART = 4'd10;
  localparam logic [3:0] S_QWAIT  = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0]             state;
  tts_pkg::tts_job_t      job;
  logic [SAMPLE_BITS-1:0] mem [HISTORY_DEPTH];
  logic [IDXW-1:0]        rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   wr_en;
  logic [IDXW-1:0]        wr_addr;
  logic [IDXW-1:0]        ptr;
  logic [IDXW-1:0]        oldest;
  logic [IDXW-1:0]        oldest_inc;
  logic                   primed;
  logic [TOTW-1:0]        total;
  logic [SAMPLE_BITS-1:0] avg;
  logic [IDXW-1:0]        ra;
  logic [IDXW-1:0]        rx;
  logic [IDXW-1:0]        px;
  logic                   pvalid;
  logic [T1W-1:0]         t1;
  logic [WAW-1:0]         term_a;
  logic [WAW-1:0]         term_b;
  logic [WAW-1:0]         mag;
  logic                   neg;
  logic [DW-1:0]          w;
  logic [DW-1:0]          den;
  logic [NW-1:0]          qnum;
  logic [tts_pkg::SLOPE_W-1:0] res;
  logic [tts_pkg::SLOPE_W-1:0] sat;
  logic                   div_start;
  logic [NW-1:0]          div_num;
  logic [DW-1:0]          div_den;
  logic                   div_done;
  logic [NW-1:0]          div_quo;
  logic                   out_free;

  assign oldest_inc = (oldest == LAST) ? '0 : oldest + 1'b1;
  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && !q_empty;

  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(q_head.num);
    div_den   = DW'(q_head.cnt);
    if (state == S_IDLE) begin
      div_start = !q_empty;
    end else if (state == S_QSTART) begin
      div_start = den != '0;
      div_num   = qnum;
      div_den   = den;
    end
  end

  always_comb begin
    rd_addr = ra;
    if (state == S_AVG) rd_addr = oldest;
    wr_en   = (state == S_FILL) || (state == S_OLD);
    wr_addr = (state == S_FILL) ? ptr : oldest;
  end

  // truncated magnitude quotient, sign restored, clamped to 16 bits
  always_comb begin
    if (!neg) begin
      sat = (div_quo > NW'(32767)) ? 16'h7fff : div_quo[15:0];
    end else begin
      sat = (div_quo > NW'(32768)) ? 16'h8000 : 16'(~div_quo[15:0] + 16'd1);
    end
  end

  tts_div #(.NUM_W(NW), .DIV_W(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= avg;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pvalid) begin
      t1 <= t1 + T1W'(px) * T1W'(rd_data);
    end
    unique case (state)
      S_IDLE: begin
        if (!q_empty) job <= q_head;
      end
      S_AVG: begin
        if (div_done) begin
          avg <= div_quo[SAMPLE_BITS-1:0];
          ptr <= '0;
          if (!primed) total <= '0;
        end
      end
      S_FILL: begin
        total <= total + TOTW'(avg);
        ptr   <= ptr + 1'b1;
        ra    <= '0;
        rx    <= '0;
        t1    <= '0;
      end
      S_OLD: begin
        total <= total - TOTW'(rd_data) + TOTW'(avg);
        ra    <= oldest_inc;
        rx    <= '0;
        t1    <= '0;
      end
      S_SWEEP: begin
        ra <= (ra == LAST) ? '0 : ra + 1'b1;
        rx <= rx + 1'b1;
        px <= rx;
      end
      S_PROD: begin
        term_a <= WAW'(t1) * WAW'(HISTORY_DEPTH);
        term_b <= WAW'(total) * S1;
        w      <= KW * DW'(job.period);
      end
      S_DIFF: begin
        neg <= term_b > term_a;
        mag <= (term_b > term_a) ? term_b - term_a : term_a - term_b;
      end
      S_HALVE: begin
        if (mag > WAW'(tts_pkg::SLOPE_LIMIT)) begin
          mag <= mag >> 1;
          w   <= w >> 1;
        end
      end
      S_SCALE: begin
        den  <= w * DW'(job.navg);
        qnum <= NW'(mag[15:0]) * NW'(tts_pkg::MS_PER_MINUTE);
      end
      S_QSTART: begin
        res <= '0;
      end
      S_QWAIT: begin
        if (div_done) res <= sat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      primed    <= 1'b0;
      oldest    <= '0;
      pvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) state <= S_AVG;
        end
        S_AVG: begin
          if (div_done) state <= primed ? S_OLD : S_FILL;
        end
        S_FILL: begin
          if (ptr == LAST) begin
            primed <= 1'b1;
            oldest <= '0;
            state  <= S_SWEEP;
          end
        end
        S_OLD: begin
          oldest <= oldest_inc;
          state  <= S_SWEEP;
        end
        S_SWEEP: begin
          pvalid <= 1'b1;
          if (rx == LAST) state <= S_DRAIN;
        end
        S_DRAIN: begin
          pvalid <= 1'b0;
          state  <= S_PROD;
        end
        S_PROD:   state <= S_DIFF;
        S_DIFF:   state <= S_HALVE;
        S_HALVE: begin
          if (mag <= WAW'(tts_pkg::SLOPE_LIMIT)) state <= S_SCALE;
        end
        S_SCALE:  state <= S_QSTART;
        S_QSTART: state <= (den == '0) ? S_OUT : S_QWAIT;
        S_QWAIT: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      slope <= res;
    end
  end

endmodule

// ===== rtl/temperature_trend_slope_core.sv =====
// top level of the temperature trend slope block
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------
//  input    | in_valid / in_stall       | temperature_sample
//  result   | out_valid / out_stall     | slope (signed)
//  config   | cfg_valid / cfg_ready     | rate_mode
//
// a sample is taken each cycle unless the two-word job queue is full
// a finished group passes the back end in order: pop, average division, history write,
//   sweep, drain and products, halvings and scaling, scale and start, slope division and
//   output; the first group writes its average into every history entry before the sweep
// reset is synchronous and clears the mode to 8 and empties all control state
// a stalled result holds the back end, the queue then fills and stalls the input
module temperature_trend_slope_core #(
  parameter int HISTORY_DEPTH = 64,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SAMPLE_BITS-1:0]            temperature_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tts_pkg::SLOPE_W-1:0]       slope,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tts_pkg::MODE_W-1:0]        rate_mode
);

  logic [tts_pkg::MODE_W-1:0] mode_sel;
  logic [tts_pkg::MODE_W-1:0] mode_eff;
  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_empty;
  tts_pkg::tts_job_t          q_in;
  tts_pkg::tts_job_t          q_head;

  assign cfg_ready = 1'b1;
  // modes above the table behave as the last one
  assign mode_eff  = (mode_sel > tts_pkg::MODE_LAST) ? tts_pkg::MODE_LAST : mode_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel <= tts_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_sel <= rate_mode;
    end
  end

  tts_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .temperature_sample (temperature_sample),
    .mode               (mode_eff),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_in)
  );

  tts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tts_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slope     (slope)
  );

endmodule
